// ----- hw/rtl/lrulk_pkg.sv -----
package lrulk_pkg;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    localparam int ACT_LO   = 0;
    localparam int ACT_W    = 3;
    localparam int IDX_LO   = 3;
    localparam int IDX_W    = 8;
    localparam int FIXED_B  = 11;
    localparam int PREC_B   = 12;

    localparam int STS_W    = 2;
    localparam int LOCK_W   = 16;
    localparam int OSTAMP_W = 16;

    localparam int AGE_SHIFT = 3;
    localparam logic [LOCK_W-1:0] LOCK_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ACT_ASSIGN = 3'd0,
        ACT_LOCK   = 3'd1,
        ACT_UNLOCK = 3'd2,
        ACT_FREE   = 3'd3,
        ACT_VICTIM = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_REFUSED   = 2'd1,
        STS_NO_VICTIM = 2'd2
    } sts_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLEAR,
        CMD_READ,
        CMD_BYPASS,
        CMD_UPDATE,
        CMD_VSCAN,
        CMD_ASCAN,
        CMD_VCOMMIT,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic is_victim;
        logic is_bypass;
        logic age_hit;
        logic scan_done;
        logic clear_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- hw/rtl/lru_lock_replacement_policy_top.sv -----
// channel | dir | tdata fields, lowest bit first
// s_      | in  | action[2:0], entry_index[10:3], fixed_attr[11], precious_attr[12], zero fill
// m_      | out | status[1:0], result_index[9:2], lock_count[25:10], use_stamp[41:26], zero fill
//
// assign, unlock and free go through READ, UPDATE and EMIT to m_tvalid, ignored actions skip UPDATE
// a lock does the same, plus an AGE pass over all entries when the use counter ages all stamps
// a victim search scans the directory in VSCAN, one directory entry read per cycle, then VCOMMIT
// after reset every directory entry is cleared before s_tready rises
// a result waits in the output register while m_tready is low; one more item is
// taken in and its result waits behind it, holding back the input
module lru_lock_replacement_policy_top #(
    parameter int ENTRIES    = 256,
    parameter int STAMP_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrulk_pkg::S_TDATA_W-1:0] s_tdata,   // action, entry_index, fixed_attr, precious_attr
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lrulk_pkg::M_TDATA_W-1:0] m_tdata    // status, result_index, lock_count, use_stamp
);

    lrulk_pkg::cmd_t     cmd;
    lrulk_pkg::dp_stat_t stat;

    lrulk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    lrulk_dp #(
        .ENTRIES    (ENTRIES),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .stat     (stat)
    );

endmodule

// ----- hw/rtl/lrulk_ctrl.sv -----
module lrulk_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  lrulk_pkg::dp_stat_t stat,
    output logic                s_tready,
    output lrulk_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_AGE,
        ST_VSCAN,
        ST_VCOMMIT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = lrulk_pkg::CMD_NONE;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd = lrulk_pkg::CMD_CLEAR;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd        = lrulk_pkg::CMD_LOAD;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (stat.is_victim) begin
                    state_next = ST_VSCAN;
                end else if (stat.is_bypass) begin
                    cmd        = lrulk_pkg::CMD_BYPASS;
                    state_next = ST_EMIT;
                end else begin
                    cmd        = lrulk_pkg::CMD_READ;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd        = lrulk_pkg::CMD_UPDATE;
                state_next = stat.age_hit ? ST_AGE : ST_EMIT;
            end
            ST_AGE: begin
                cmd = lrulk_pkg::CMD_ASCAN;
                if (stat.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_VSCAN: begin
                cmd = lrulk_pkg::CMD_VSCAN;
                if (stat.scan_done) begin
                    state_next = ST_VCOMMIT;
                end
            end
            ST_VCOMMIT: begin
                cmd        = lrulk_pkg::CMD_VCOMMIT;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd        = lrulk_pkg::CMD_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lrulk_dp.sv -----
module lrulk_dp #(
    parameter int ENTRIES    = 256,
    parameter int STAMP_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lrulk_pkg::cmd_t                   cmd,
    input  logic [lrulk_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [lrulk_pkg::M_TDATA_W-1:0]   m_tdata,
    output lrulk_pkg::dp_stat_t               stat
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int SB    = STAMP_BITS;
    localparam int LW    = lrulk_pkg::LOCK_W;
    localparam int IW    = lrulk_pkg::IDX_W;
    localparam int WW    = SB + LW + 4;
    localparam int IXW   = AW + IW;
    localparam int LK_LO = SB;
    localparam int FR_B  = SB + LW;
    localparam int DI_B  = SB + LW + 1;
    localparam int PR_B  = SB + LW + 2;
    localparam int FX_B  = SB + LW + 3;
    localparam int OW    = lrulk_pkg::OSTAMP_W;

    function automatic logic [OW-1:0] stamp_out(input logic [SB-1:0] s);
        logic [SB+OW-1:0] w;
        w = {{OW{1'b0}}, s};
        return w[OW-1:0];
    endfunction

    logic [WW-1:0] mem [ENTRIES];

    logic [2:0]    act_reg, act_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          fx_reg, fx_next;
    logic          pr_reg, pr_next;
    logic [SB-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          found_reg, found_next;
    logic [AW-1:0] best_addr_reg, best_addr_next;
    logic [WW-1:0] best_word_reg, best_word_next;
    logic [WW-1:0] rd_q_reg;
    logic [1:0]    res_status_reg, res_status_next;
    logic [IW-1:0] res_index_reg, res_index_next;
    logic [LW-1:0] res_locks_reg, res_locks_next;
    logic [OW-1:0] res_stamp_reg, res_stamp_next;
    logic          out_valid_reg, out_valid_next;
    logic [lrulk_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [IXW-1:0] idx_wide;
    logic           idx_ok;
    logic [AW-1:0]  idx_addr;
    logic           scan_in;
    logic [AW-1:0]  scan_addr;
    logic [AW-1:0]  rd_addr;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [WW-1:0]  mem_wd;
    logic [WW-1:0]  clr_word;
    logic [WW-1:0]  upd_word;
    logic [WW-1:0]  aged_word;
    logic [WW-1:0]  disc_word;
    logic           q_fx, q_pr, q_di, q_fr;
    logic [LW-1:0]  q_lk;
    logic [SB-1:0]  q_st;
    logic           refused;
    logic           elig;
    logic           better;
    logic [SB-1:0]  cnt_inc;
    logic [SB-1:0]  cnt_aged;
    logic           age_hit;
    logic [LW-1:0]  lk_sat;
    logic [LW-1:0]  lk_dec;
    logic [IXW-1:0] best_wide;
    logic           act_known;

    assign idx_wide  = {{AW{1'b0}}, idx_reg};
    assign idx_ok    = idx_wide < IXW'(ENTRIES);
    assign idx_addr  = idx_ok ? idx_wide[AW-1:0] : '0;
    assign scan_in   = scan_cnt_reg < CW'(ENTRIES);
    assign scan_addr = scan_in ? scan_cnt_reg[AW-1:0] : '0;
    assign rd_addr   = (cmd == lrulk_pkg::CMD_READ) ? idx_addr : scan_addr;
    assign best_wide = {{IW{1'b0}}, best_addr_reg};

    assign q_fx = rd_q_reg[FX_B];
    assign q_pr = rd_q_reg[PR_B];
    assign q_di = rd_q_reg[DI_B];
    assign q_fr = rd_q_reg[FR_B];
    assign q_lk = rd_q_reg[LK_LO +: LW];
    assign q_st = rd_q_reg[SB-1:0];

    assign refused  = q_fx | q_pr | q_fr;
    assign elig     = !q_fx && !q_pr && !q_di && !q_fr && (q_lk == '0);
    assign better   = !found_reg || (q_st < best_word_reg[SB-1:0]);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign cnt_aged = cnt_inc >> lrulk_pkg::AGE_SHIFT;
    assign age_hit  = (act_reg == lrulk_pkg::ACT_LOCK) && !refused && (cnt_inc == '1);
    assign lk_sat   = (q_lk == lrulk_pkg::LOCK_MAX) ? q_lk : q_lk + 1'b1;
    assign lk_dec   = (q_lk != '0) ? q_lk - 1'b1 : q_lk;

    assign act_known = (act_reg == lrulk_pkg::ACT_ASSIGN) || (act_reg == lrulk_pkg::ACT_LOCK) ||
                       (act_reg == lrulk_pkg::ACT_UNLOCK) || (act_reg == lrulk_pkg::ACT_FREE);

    assign stat.is_victim  = (act_reg == lrulk_pkg::ACT_VICTIM);
    assign stat.is_bypass  = !act_known || !idx_ok;
    assign stat.age_hit    = age_hit;
    assign stat.scan_done  = !scan_in && !pend_valid_reg;
    assign stat.clear_last = scan_cnt_reg == CW'(ENTRIES - 1);
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        clr_word       = '0;
        clr_word[DI_B] = 1'b1;
        clr_word[FR_B] = 1'b1;

        aged_word          = rd_q_reg;
        aged_word[SB-1:0]  = q_st >> lrulk_pkg::AGE_SHIFT;

        disc_word       = best_word_reg;
        disc_word[DI_B] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_comb begin
        act_next        = act_reg;
        idx_next        = idx_reg;
        fx_next         = fx_reg;
        pr_next         = pr_reg;
        cnt_next        = cnt_reg;
        scan_cnt_next   = scan_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        found_next      = found_reg;
        best_addr_next  = best_addr_reg;
        best_word_next  = best_word_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_locks_next  = res_locks_reg;
        res_stamp_next  = res_stamp_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_wa          = pend_addr_reg;
        mem_wd          = rd_q_reg;
        upd_word        = rd_q_reg;

        unique case (cmd)
            lrulk_pkg::CMD_LOAD: begin
                act_next        = s_tdata[lrulk_pkg::ACT_LO +: lrulk_pkg::ACT_W];
                idx_next        = s_tdata[lrulk_pkg::IDX_LO +: IW];
                fx_next         = s_tdata[lrulk_pkg::FIXED_B];
                pr_next         = s_tdata[lrulk_pkg::PREC_B];
                scan_cnt_next   = '0;
                pend_valid_next = 1'b0;
                found_next      = 1'b0;
            end
            lrulk_pkg::CMD_CLEAR: begin
                mem_we        = 1'b1;
                mem_wa        = scan_addr;
                mem_wd        = clr_word;
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
            lrulk_pkg::CMD_BYPASS: begin
                res_status_next = lrulk_pkg::STS_DONE;
                res_index_next  = idx_reg;
                res_locks_next  = '0;
                res_stamp_next  = '0;
            end
            lrulk_pkg::CMD_UPDATE: begin
                scan_cnt_next   = '0;
                pend_valid_next = 1'b0;
                mem_wa          = idx_addr;
                res_status_next = lrulk_pkg::STS_DONE;
                res_index_next  = idx_reg;
                unique case (act_reg)
                    lrulk_pkg::ACT_ASSIGN: begin
                        upd_word           = '0;
                        upd_word[FX_B]     = fx_reg;
                        upd_word[PR_B]     = pr_reg;
                        upd_word[SB-1:0]   = cnt_reg;
                        mem_we             = 1'b1;
                        res_locks_next     = '0;
                        res_stamp_next     = stamp_out(cnt_reg);
                    end
                    lrulk_pkg::ACT_LOCK: begin
                        if (refused) begin
                            res_status_next = lrulk_pkg::STS_REFUSED;
                            res_locks_next  = q_lk;
                            res_stamp_next  = stamp_out(q_st);
                        end else begin
                            upd_word[DI_B]        = 1'b0;
                            upd_word[LK_LO +: LW] = lk_sat;
                            upd_word[SB-1:0]      = cnt_inc;
                            mem_we                = 1'b1;
                            cnt_next              = age_hit ? cnt_aged : cnt_inc;
                            res_locks_next        = lk_sat;
                            res_stamp_next        = age_hit ? stamp_out(cnt_aged)
                                                            : stamp_out(cnt_inc);
                        end
                    end
                    lrulk_pkg::ACT_UNLOCK: begin
                        upd_word[LK_LO +: LW] = lk_dec;
                        mem_we                = 1'b1;
                        res_locks_next        = lk_dec;
                        res_stamp_next        = stamp_out(q_st);
                    end
                    lrulk_pkg::ACT_FREE: begin
                        upd_word[FR_B]        = 1'b1;
                        upd_word[LK_LO +: LW] = '0;
                        mem_we                = 1'b1;
                        res_locks_next        = '0;
                        res_stamp_next        = stamp_out(q_st);
                    end
                    default: begin
                        res_locks_next = '0;
                        res_stamp_next = '0;
                    end
                endcase
                mem_wd = upd_word;
            end
            lrulk_pkg::CMD_VSCAN: begin
                pend_valid_next = scan_in;
                pend_addr_next  = scan_addr;
                if (scan_in) begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (pend_valid_reg && elig && better) begin
                    found_next     = 1'b1;
                    best_addr_next = pend_addr_reg;
                    best_word_next = rd_q_reg;
                end
            end
            lrulk_pkg::CMD_ASCAN: begin
                pend_valid_next = scan_in;
                pend_addr_next  = scan_addr;
                if (scan_in) begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (pend_valid_reg) begin
                    mem_we = 1'b1;
                    mem_wa = pend_addr_reg;
                    mem_wd = aged_word;
                end
            end
            lrulk_pkg::CMD_VCOMMIT: begin
                if (found_reg) begin
                    mem_we          = 1'b1;
                    mem_wa          = best_addr_reg;
                    mem_wd          = disc_word;
                    res_status_next = lrulk_pkg::STS_DONE;
                    res_index_next  = best_wide[IW-1:0];
                    res_locks_next  = best_word_reg[LK_LO +: LW];
                    res_stamp_next  = stamp_out(best_word_reg[SB-1:0]);
                end else begin
                    res_status_next = lrulk_pkg::STS_NO_VICTIM;
                    res_index_next  = '0;
                    res_locks_next  = '0;
                    res_stamp_next  = '0;
                end
            end
            lrulk_pkg::CMD_EMIT: begin
                out_valid_next = 1'b1;
                out_data_next  = {6'd0, res_stamp_reg, res_locks_reg,
                                  res_index_reg, res_status_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            scan_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            cnt_reg        <= cnt_next;
            scan_cnt_reg   <= scan_cnt_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        idx_reg        <= idx_next;
        fx_reg         <= fx_next;
        pr_reg         <= pr_next;
        pend_addr_reg  <= pend_addr_next;
        best_addr_reg  <= best_addr_next;
        best_word_reg  <= best_word_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_locks_reg  <= res_locks_next;
        res_stamp_reg  <= res_stamp_next;
        out_data_reg   <= out_data_next;
    end

endmodule
